// ===== rtl/shi_pkg.sv =====
// shared types, constants and helpers of the slew-limited homing integrator
// no dependencies
package shi_pkg;

	localparam int NUM_W = 55;   // dividend width: 32-bit offset times 23-bit speed
	localparam int CNT_W = 6;    // divider step counter
	localparam int DEN_W = 32;

	localparam logic [1:0] KIND_TICK     = 2'd0;
	localparam logic [1:0] KIND_LOAD_POS = 2'd1;
	localparam logic [1:0] KIND_LOAD_VEL = 2'd2;
	localparam logic [1:0] KIND_NONE     = 2'd3;

	localparam logic [2:0] REG_HOMING  = 3'd0;
	localparam logic [2:0] REG_MAXSPD  = 3'd1;
	localparam logic [2:0] REG_MAXCHG  = 3'd2;
	localparam logic [2:0] REG_STOPRNG = 3'd3;
	localparam logic [2:0] REG_ACCX    = 3'd4;
	localparam logic [2:0] REG_ACCY    = 3'd5;
	localparam logic [2:0] REG_ACCZ    = 3'd6;
	localparam logic [2:0] REG_VLIM    = 3'd7;

	typedef struct packed {
		logic cap_d;
		logic load_pos;
		logic load_vel;
		logic div1;
		logic cap_q;
		logic div2;
		logic steer;
		logic homing;
		logic vel;
		logic pos;
	} ctl_t;

	function automatic logic signed [23:0] clamp_v(input logic signed [33:0] x,
		input logic [22:0] lim);
		logic signed [33:0] l;
		logic signed [33:0] r;
		l = $signed({11'd0, lim});
		if (x > l) begin
			r = l;
		end else if (x < -l) begin
			r = -l;
		end else begin
			r = x;
		end
		return r[23:0];
	endfunction

endpackage

// ===== rtl/shi_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on shi_pkg
module shi_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [shi_pkg::NUM_W-1:0] num,
	input  logic [shi_pkg::DEN_W-1:0] den,
	output logic [shi_pkg::NUM_W-1:0] quo,
	output logic                      done
);
	import shi_pkg::*;

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   rem_t;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign rem_t = {rem_q, num_q[NUM_W-1]};
	assign diff  = rem_t - {1'b0, den_q};
	assign ge    = rem_t >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : rem_t[DEN_W-1:0];
		end
	end

	assign quo  = num_q;
	assign done = done_q;
endmodule

// ===== rtl/shi_lane.sv =====
// one axis: position and velocity state, homing steer, integrate
// depends on shi_pkg and shi_div
module shi_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  shi_pkg::ctl_t       ctl,
	input  logic signed [31:0]  target,
	input  logic signed [31:0]  load,
	input  logic signed [23:0]  accel,
	input  logic [22:0]         max_speed,
	input  logic [22:0]         max_speed_change,
	input  logic [23:0]         stop_eff,
	input  logic [22:0]         velocity_limit,
	input  logic [31:0]         max_mag,
	output logic [31:0]         dmag,
	output logic [31:0]         pos,
	output logic signed [23:0]  vel,
	output logic                div_done
);
	import shi_pkg::*;

	logic [31:0]        pos_q;
	logic signed [23:0] vel_q;
	logic               dneg_q;
	logic [31:0]        dmag_q;
	logic signed [25:0] vs_q;
	logic [31:0]        d;
	logic [NUM_W-1:0]   num;
	logic [DEN_W-1:0]   den;
	logic [NUM_W-1:0]   quo;
	logic signed [48:0] w;
	logic signed [48:0] lo;
	logic signed [48:0] hi;
	logic signed [26:0] t;

	assign d   = target - pos_q;
	assign num = NUM_W'(dmag_q) * NUM_W'(max_speed);
	assign den = ctl.div1 ? max_mag : {8'd0, stop_eff};

	shi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctl.div1 | ctl.div2),
		.num   (num),
		.den   (den),
		.quo   (quo),
		.done  (div_done)
	);

	always_comb begin
		w  = $signed({2'b00, quo[46:0]});
		if (dneg_q) begin
			w = -w;
		end
		lo = 49'(vel_q) - $signed({26'd0, max_speed_change});
		hi = 49'(vel_q) + $signed({26'd0, max_speed_change});
		t  = 27'(vs_q) + 27'(accel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			vel_q <= '0;
		end else begin
			if (ctl.load_pos) begin
				pos_q <= load;
			end
			if (ctl.load_vel) begin
				vel_q <= clamp_v(34'(load), velocity_limit);
			end
			if (ctl.vel) begin
				vel_q <= clamp_v(34'(t), velocity_limit);
			end
			if (ctl.pos) begin
				pos_q <= pos_q + 32'(vel_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_d) begin
			dneg_q <= d[31];
			dmag_q <= d[31] ? (~d + 32'd1) : d;
		end
		if (ctl.cap_q) begin
			dmag_q <= quo[31:0];
		end
		if (ctl.steer) begin
			if (!ctl.homing) begin
				vs_q <= 26'(vel_q);
			end else if (w < lo) begin
				vs_q <= lo[25:0];
			end else if (w > hi) begin
				vs_q <= hi[25:0];
			end else begin
				vs_q <= w[25:0];
			end
		end
	end

	assign dmag = dmag_q;
	assign pos  = pos_q;
	assign vel  = vel_q;
endmodule

// ===== rtl/slew_limited_homing_integrator.sv =====
// top level: config registers, sequencer, largest-offset merge, three axis lanes
// depends on shi_pkg, shi_lane, shi_div
// sequence: loads and unused kinds go straight to the done state; a tick runs steer, velocity
// and position steps, with homing first one or two 55-step divisions, two when rescaled first
// one word at a time: the next word is taken the cycle after the result is registered
// reset (arst_n low) clears position, velocity, registers to defaults, output valid
module slew_limited_homing_integrator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // target_x, target_y, target_z, load_x, load_y, load_z
	input  logic [1:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [167:0] m_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import shi_pkg::*;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MAX   = 4'd1;
	localparam logic [3:0] S_ST1   = 4'd2;
	localparam logic [3:0] S_DV1   = 4'd3;
	localparam logic [3:0] S_ST2   = 4'd4;
	localparam logic [3:0] S_DV2   = 4'd5;
	localparam logic [3:0] S_STEER = 4'd6;
	localparam logic [3:0] S_VEL   = 4'd7;
	localparam logic [3:0] S_POS   = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	// configuration registers
	logic               homing_q;
	logic [22:0]        max_speed_q;
	logic [22:0]        max_chg_q;
	logic [23:0]        stop_q;
	logic signed [23:0] acc_x_q, acc_y_q, acc_z_q;
	logic [22:0]        vlim_q;
	logic               wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homing_q    <= 1'b0;
			max_speed_q <= 23'd1000;
			max_chg_q   <= 23'd1000;
			stop_q      <= 24'd1000;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_z_q     <= '0;
			vlim_q      <= 23'd256000;
		end else if (wr) begin
			unique case (paddr[4:2])
				REG_HOMING:  homing_q    <= pwdata[0];
				REG_MAXSPD:  max_speed_q <= pwdata[22:0];
				REG_MAXCHG:  max_chg_q   <= pwdata[22:0];
				REG_STOPRNG: stop_q      <= pwdata[23:0];
				REG_ACCX:    acc_x_q     <= pwdata[23:0];
				REG_ACCY:    acc_y_q     <= pwdata[23:0];
				REG_ACCZ:    acc_z_q     <= pwdata[23:0];
				REG_VLIM:    vlim_q      <= pwdata[22:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_HOMING:  prdata = {31'd0, homing_q};
			REG_MAXSPD:  prdata = {9'd0, max_speed_q};
			REG_MAXCHG:  prdata = {9'd0, max_chg_q};
			REG_STOPRNG: prdata = {8'd0, stop_q};
			REG_ACCX:    prdata = 32'(acc_x_q);
			REG_ACCY:    prdata = 32'(acc_y_q);
			REG_ACCZ:    prdata = 32'(acc_z_q);
			REG_VLIM:    prdata = {9'd0, vlim_q};
			default:     prdata = '0;
		endcase
	end

	// sequencer
	logic [3:0]  st_q;
	logic [3:0]  st_nxt;
	logic        scale_q;     // largest offset exceeds top speed
	logic [31:0] mag_max_q;
	logic [31:0] mag_max;
	logic        acc;
	logic [1:0]  kind;
	logic        all_done;
	ctl_t        ctl;
	logic [31:0] dmag_x, dmag_y, dmag_z;
	logic [31:0] pos_x, pos_y, pos_z;
	logic signed [23:0] vel_x, vel_y, vel_z;
	logic        dn_x, dn_y, dn_z;
	logic        out_free;
	logic [23:0] stop_eff;

	assign s_tready = (st_q == S_IDLE);
	assign acc      = s_tvalid & s_tready;
	assign kind     = s_tuser;
	assign all_done = dn_x & dn_y & dn_z;
	assign out_free = !m_tvalid || m_tready;
	// a zero stop range behaves as one
	assign stop_eff = (stop_q == '0) ? 24'd1 : stop_q;

	// merge: largest offset magnitude over the three lanes
	always_comb begin
		mag_max = dmag_x;
		if (dmag_y > mag_max) begin
			mag_max = dmag_y;
		end
		if (dmag_z > mag_max) begin
			mag_max = dmag_z;
		end
	end

	always_comb begin
		ctl          = '0;
		ctl.homing   = homing_q;
		st_nxt       = st_q;
		ctl.cap_d    = acc && kind == KIND_TICK;
		ctl.load_pos = acc && kind == KIND_LOAD_POS;
		ctl.load_vel = acc && kind == KIND_LOAD_VEL;
		unique case (st_q)
			S_IDLE: begin
				if (acc) begin
					if (kind != KIND_TICK) begin
						st_nxt = S_DONE;
					end else if (homing_q) begin
						st_nxt = S_MAX;
					end else begin
						st_nxt = S_STEER;
					end
				end
			end
			S_MAX:   st_nxt = S_ST1;
			S_ST1: begin
				// rescale only when the largest offset is above top speed
				ctl.div1 = scale_q;
				st_nxt   = scale_q ? S_DV1 : S_ST2;
			end
			S_DV1: begin
				if (all_done) begin
					ctl.cap_q = 1'b1;
					st_nxt    = S_ST2;
				end
			end
			S_ST2: begin
				ctl.div2 = 1'b1;
				st_nxt   = S_DV2;
			end
			S_DV2: begin
				if (all_done) begin
					st_nxt = S_STEER;
				end
			end
			S_STEER: begin
				ctl.steer = 1'b1;
				st_nxt    = S_VEL;
			end
			S_VEL: begin
				ctl.vel = 1'b1;
				st_nxt  = S_POS;
			end
			S_POS: begin
				ctl.pos = 1'b1;
				st_nxt  = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					st_nxt = S_IDLE;
				end
			end
			default: st_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (st_q == S_DONE && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_MAX) begin
			mag_max_q <= mag_max;
			scale_q   <= mag_max > {9'd0, max_speed_q};
		end
		if (st_q == S_DONE && out_free) begin
			m_tdata <= {vel_z, vel_y, vel_x, pos_z, pos_y, pos_x};
		end
	end

	shi_lane u_lane_x (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.target(s_tdata[31:0]), .load(s_tdata[127:96]), .accel(acc_x_q),
		.max_speed(max_speed_q), .max_speed_change(max_chg_q), .stop_eff(stop_eff),
		.velocity_limit(vlim_q), .max_mag(mag_max_q),
		.dmag(dmag_x), .pos(pos_x), .vel(vel_x), .div_done(dn_x)
	);

	shi_lane u_lane_y (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.target(s_tdata[63:32]), .load(s_tdata[159:128]), .accel(acc_y_q),
		.max_speed(max_speed_q), .max_speed_change(max_chg_q), .stop_eff(stop_eff),
		.velocity_limit(vlim_q), .max_mag(mag_max_q),
		.dmag(dmag_y), .pos(pos_y), .vel(vel_y), .div_done(dn_y)
	);

	shi_lane u_lane_z (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.target(s_tdata[95:64]), .load(s_tdata[191:160]), .accel(acc_z_q),
		.max_speed(max_speed_q), .max_speed_change(max_chg_q), .stop_eff(stop_eff),
		.velocity_limit(vlim_q), .max_mag(mag_max_q),
		.dmag(dmag_z), .pos(pos_z), .vel(vel_z), .div_done(dn_z)
	);

	// one word in flight: no second accept right after the first
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("word accepted while busy");

	// a result is only presented from the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(st_q) == S_DONE)
		else $error("result raised outside done state");

	// the rescale division only runs when the merged offset exceeds top speed
	a_div1_scaled: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DV1 |-> scale_q)
		else $error("rescale division without need");
endmodule
